>>> sv/rpi_pkg.sv
package rpi_pkg;

  localparam int VEC_W  = 20;
  localparam int QP_W   = 15;
  localparam int CS_W   = 22;
  localparam int X_W    = 30;
  localparam int Y_W    = 33;
  localparam int Y2_W   = 36;

  localparam logic [31:0] SEED_A   = 32'd2369748206;
  localparam logic [30:0] SEED_B   = 31'd1431655765;
  localparam logic [31:0] THREE_Q30 = 32'd3221225472;

  localparam logic [1:0] REG_TIME_STEP    = 2'd0;
  localparam logic [1:0] REG_SPLIT_ENABLE = 2'd1;

  typedef struct packed {
    logic [59:0]                pos;
    logic [3:0][CS_W-1:0]       cs;
    logic                       zero;
  } side_t;

endpackage

>>> sv/rpi_motion.sv
module rpi_motion import rpi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [15:0] dt,
  input  logic        split,
  input  logic [59:0] lin,
  input  logic [59:0] ang,
  input  logic [59:0] slin,
  input  logic [59:0] sang,
  input  logic [59:0] pos,
  input  logic [59:0] ori,
  output logic        out_valid,
  output side_t       out_side
);

  logic               v1, v2, v3, v4, v5;
  logic signed [20:0] s1_v [3];
  logic signed [20:0] s1_w [3];
  logic signed [19:0] s1_p [3];
  logic signed [14:0] s1_q [4];
  logic [15:0]        s1_dt;

  logic signed [37:0] s2_vdt [3];
  logic signed [37:0] s2_r   [4];
  logic signed [19:0] s2_p   [3];
  logic signed [14:0] s2_q   [4];
  logic [15:0]        s2_dt;

  logic [59:0]        s3_pos;
  logic signed [54:0] s3_rdt [4];
  logic signed [14:0] s3_q   [4];

  logic [59:0]        s4_pos;
  logic [43:0]        s4_mag [4];
  logic [3:0]         s4_neg;
  logic [43:0]        s4_or;

  logic signed [20:0] sum_v [3];
  logic signed [20:0] sum_w [3];
  logic signed [35:0] pq    [12];
  logic signed [37:0] pqx   [12];
  logic signed [37:0] rn    [4];
  logic signed [37:0] vdt_n [3];
  logic [59:0]        pos_n;
  logic signed [54:0] rdt_n [4];
  logic [43:0]        mag_n [4];
  logic [3:0]         neg_n;
  logic [43:0]        or_n;
  logic [5:0]         len;
  side_t              side_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_v[i] = 21'($signed(lin[VEC_W*i +: VEC_W]));
      sum_w[i] = 21'($signed(ang[VEC_W*i +: VEC_W]));
      if (split) begin
        sum_v[i] = sum_v[i] + 21'($signed(slin[VEC_W*i +: VEC_W]));
        sum_w[i] = sum_w[i] + 21'($signed(sang[VEC_W*i +: VEC_W]));
      end
    end
  end

  always_comb begin
    pq[0]  = s1_w[0] * s1_q[1];
    pq[1]  = s1_w[1] * s1_q[2];
    pq[2]  = s1_w[2] * s1_q[3];
    pq[3]  = s1_w[0] * s1_q[0];
    pq[4]  = s1_w[1] * s1_q[3];
    pq[5]  = s1_w[2] * s1_q[2];
    pq[6]  = s1_w[1] * s1_q[0];
    pq[7]  = s1_w[2] * s1_q[1];
    pq[8]  = s1_w[0] * s1_q[3];
    pq[9]  = s1_w[2] * s1_q[0];
    pq[10] = s1_w[0] * s1_q[2];
    pq[11] = s1_w[1] * s1_q[1];
    for (int i = 0; i < 12; i++) begin
      pqx[i] = 38'(pq[i]);
    end
    rn[0] = -(pqx[0] + pqx[1] + pqx[2]);
    rn[1] = pqx[3] + pqx[4] - pqx[5];
    rn[2] = pqx[6] + pqx[7] - pqx[8];
    rn[3] = pqx[9] + pqx[10] - pqx[11];
    for (int i = 0; i < 3; i++) begin
      vdt_n[i] = 38'(s1_v[i] * $signed({1'b0, s1_dt}));
    end
  end

  always_comb begin
    logic signed [37:0] t;
    logic signed [21:0] np;
    pos_n = '0;
    for (int i = 0; i < 3; i++) begin
      t  = s2_vdt[i] + 38'sd131072;
      np = 22'(s2_p[i]) + 22'(t >>> 18);
      if (np > 22'sd524287) begin
        np = 22'sd524287;
      end else if (np < -22'sd524288) begin
        np = -22'sd524288;
      end
      pos_n[VEC_W*i +: VEC_W] = np[19:0];
    end
    for (int i = 0; i < 4; i++) begin
      rdt_n[i] = 55'(s2_r[i] * $signed({1'b0, s2_dt}));
    end
  end

  always_comb begin
    logic signed [54:0] t;
    logic signed [43:0] c;
    or_n = '0;
    for (int i = 0; i < 4; i++) begin
      t  = s3_rdt[i] + 55'sd4096;
      c  = (44'(s3_q[i]) <<< 14) + 44'(t >>> 13);
      neg_n[i] = c[43];
      mag_n[i] = c[43] ? 44'(-c) : 44'(c);
      or_n = or_n | mag_n[i];
    end
  end

  always_comb begin
    logic [43:0] m;
    len = '0;
    for (int b = 0; b < 44; b++) begin
      if (s4_or[b]) begin
        len = 6'(b + 1);
      end
    end
    side_n.pos  = s4_pos;
    side_n.zero = (s4_or == '0);
    for (int i = 0; i < 4; i++) begin
      if (len > 6'd21) begin
        m = s4_mag[i] >> (len - 6'd21);
      end else begin
        m = s4_mag[i] << (6'd21 - len);
      end
      side_n.cs[i] = s4_neg[i] ? -{1'b0, m[20:0]} : {1'b0, m[20:0]};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s1_v[i]   <= sum_v[i];
      s1_w[i]   <= sum_w[i];
      s1_p[i]   <= $signed(pos[VEC_W*i +: VEC_W]);
      s2_vdt[i] <= vdt_n[i];
      s2_p[i]   <= s1_p[i];
    end
    for (int i = 0; i < 4; i++) begin
      s1_q[i]   <= $signed(ori[QP_W*i +: QP_W]);
      s2_r[i]   <= rn[i];
      s2_q[i]   <= s1_q[i];
      s3_rdt[i] <= rdt_n[i];
      s3_q[i]   <= s2_q[i];
      s4_mag[i] <= mag_n[i];
    end
    s1_dt    <= dt;
    s2_dt    <= s1_dt;
    s3_pos   <= pos_n;
    s4_pos   <= s3_pos;
    s4_neg   <= neg_n;
    s4_or    <= or_n;
    out_side <= side_n;
  end

  assign out_valid = v5;

endmodule

>>> sv/rpi_rsqrt.sv
module rpi_rsqrt import rpi_pkg::*; #(
  parameter int NORM_ITERATIONS = 3
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  side_t          in_side,
  output logic           out_valid,
  output side_t          out_side,
  output logic           out_hi,
  output logic [Y_W-1:0] out_y
);

  logic           r1_v, r2_v, r3_v;
  side_t          r1_side, r2_side, r3_side;
  logic [41:0]    r1_sq [4];
  logic [X_W-1:0] r2_x, r3_x;
  logic           r2_hi, r3_hi;
  logic [Y_W-1:0] r3_y;

  logic [43:0]    s_sum;
  logic [60:0]    seed_p;

  logic           bv [NORM_ITERATIONS+1];
  side_t          bs [NORM_ITERATIONS+1];
  logic           bh [NORM_ITERATIONS+1];
  logic [X_W-1:0] bx [NORM_ITERATIONS+1];
  logic [Y_W-1:0] by [NORM_ITERATIONS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_v <= 1'b0;
      r2_v <= 1'b0;
      r3_v <= 1'b0;
    end else begin
      r1_v <= in_valid;
      r2_v <= r1_v;
      r3_v <= r2_v;
    end
  end

  always_comb begin
    s_sum = '0;
    for (int i = 0; i < 4; i++) begin
      s_sum = s_sum + 44'(r1_sq[i]);
    end
    seed_p = r2_x * SEED_B;
  end

  always_ff @(posedge clk) begin
    logic signed [43:0] sq;
    for (int i = 0; i < 4; i++) begin
      sq = $signed(in_side.cs[i]) * $signed(in_side.cs[i]);
      r1_sq[i] <= sq[41:0];
    end
    r1_side <= in_side;
    r2_side <= r1_side;
    r2_hi   <= (s_sum[43:42] != 2'b00);
    r2_x    <= (s_sum[43:42] != 2'b00) ? s_sum[43:14] : s_sum[41:12];
    r3_side <= r2_side;
    r3_hi   <= r2_hi;
    r3_x    <= r2_x;
    r3_y    <= Y_W'(SEED_A) - Y_W'(seed_p[60:30]);
  end

  assign bv[0] = r3_v;
  assign bs[0] = r3_side;
  assign bh[0] = r3_hi;
  assign bx[0] = r3_x;
  assign by[0] = r3_y;

  for (genvar k = 0; k < NORM_ITERATIONS; k++) begin : g_newton
    logic            va, vb, vc;
    side_t           sa, sb, sc;
    logic            ha, hb, hc;
    logic [X_W-1:0]  xa, xb, xc;
    logic [Y_W-1:0]  ya, yb, yc;
    logic [Y2_W-1:0] y2a;
    logic [31:0]     tb;
    logic [65:0]     y2_p;
    logic [65:0]     t_p;
    logic [64:0]     y_p;

    always_ff @(posedge clk) begin
      if (rst) begin
        va <= 1'b0;
        vb <= 1'b0;
        vc <= 1'b0;
      end else begin
        va <= bv[k];
        vb <= va;
        vc <= vb;
      end
    end

    always_comb begin
      y2_p = by[k] * by[k];
      t_p  = xa * y2a;
      y_p  = yb * (THREE_Q30 - tb);
    end

    always_ff @(posedge clk) begin
      sa  <= bs[k];
      ha  <= bh[k];
      xa  <= bx[k];
      ya  <= by[k];
      y2a <= y2_p[65:30];
      sb  <= sa;
      hb  <= ha;
      xb  <= xa;
      yb  <= ya;
      tb  <= (t_p[65:30] > 36'(THREE_Q30)) ? THREE_Q30 : t_p[61:30];
      sc  <= sb;
      hc  <= hb;
      xc  <= xb;
      yc  <= y_p[63:31];
    end

    assign bv[k+1] = vc;
    assign bs[k+1] = sc;
    assign bh[k+1] = hc;
    assign bx[k+1] = xc;
    assign by[k+1] = yc;
  end

  assign out_valid = bv[NORM_ITERATIONS];
  assign out_side  = bs[NORM_ITERATIONS];
  assign out_hi    = bh[NORM_ITERATIONS];
  assign out_y     = by[NORM_ITERATIONS];

  logic unused_x;
  assign unused_x = ^bx[NORM_ITERATIONS];

endmodule

>>> sv/rpi_scale.sv
module rpi_scale import rpi_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  side_t          in_side,
  input  logic           in_hi,
  input  logic [Y_W-1:0] in_y,
  output logic           done,
  output logic [59:0]    new_position,
  output logic [59:0]    new_orientation
);

  logic               o1_v;
  logic signed [55:0] o1_p [4];
  logic [59:0]        o1_pos;
  logic               o1_hi, o1_zero;
  logic [59:0]        ori_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      o1_v <= 1'b0;
      done <= 1'b0;
    end else begin
      o1_v <= in_valid;
      done <= o1_v;
    end
  end

  always_comb begin
    logic signed [55:0] t;
    logic signed [18:0] a;
    ori_n = '0;
    for (int i = 0; i < 4; i++) begin
      if (o1_hi) begin
        t = o1_p[i] + 56'sd137438953472;
        a = 19'(t >>> 38);
      end else begin
        t = o1_p[i] + 56'sd68719476736;
        a = 19'(t >>> 37);
      end
      if (a > 19'sd16383) begin
        a = 19'sd16383;
      end else if (a < -19'sd16384) begin
        a = -19'sd16384;
      end
      ori_n[QP_W*i +: QP_W] = a[14:0];
    end
    if (o1_zero) begin
      ori_n = {45'd0, 15'd16383};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      o1_p[i] <= 56'($signed(in_side.cs[i]) * $signed({1'b0, in_y}));
    end
    o1_pos          <= in_side.pos;
    o1_hi           <= in_hi;
    o1_zero         <= in_side.zero;
    new_position    <= o1_pos;
    new_orientation <= ori_n;
  end

endmodule

>>> sv/rigid_pose_integrate_core.sv
// Pose integrator for one rigid body per transaction: position advances by
// velocity times the time step and the orientation quaternion is stepped and
// renormalised. A new body is taken every clock cycle and busy never rises.
// Each result appears on the done strobe after the motion, inverse square root
// and scaling stages; the depth is set by the chain of multipliers, three per
// Newton step of the inverse square root. The receiver cannot stall, so a
// result must be taken in the cycle done is high. Configuration is accepted
// on every cycle and must only change while no body is in flight.
module rigid_pose_integrate_core import rpi_pkg::*; #(
  parameter int NORM_ITERATIONS = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [59:0] linear_velocity,
  input  logic [59:0] angular_velocity,
  input  logic [59:0] split_linear,
  input  logic [59:0] split_angular,
  input  logic [59:0] position,
  input  logic [59:0] orientation,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        done,
  output logic [59:0] new_position,
  output logic [59:0] new_orientation
);

  logic [15:0]    time_step;
  logic           split_enable;
  logic           m_v, q_v, q_hi;
  side_t          m_side, q_side;
  logic [Y_W-1:0] q_y;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step    <= 16'd1092;
      split_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TIME_STEP:    time_step    <= cfg_data;
        REG_SPLIT_ENABLE: split_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  rpi_motion u_motion (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .dt        (time_step),
    .split     (split_enable),
    .lin       (linear_velocity),
    .ang       (angular_velocity),
    .slin      (split_linear),
    .sang      (split_angular),
    .pos       (position),
    .ori       (orientation),
    .out_valid (m_v),
    .out_side  (m_side)
  );

  rpi_rsqrt #(.NORM_ITERATIONS(NORM_ITERATIONS)) u_rsqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (m_v),
    .in_side   (m_side),
    .out_valid (q_v),
    .out_side  (q_side),
    .out_hi    (q_hi),
    .out_y     (q_y)
  );

  rpi_scale u_scale (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (q_v),
    .in_side         (q_side),
    .in_hi           (q_hi),
    .in_y            (q_y),
    .done            (done),
    .new_position    (new_position),
    .new_orientation (new_orientation)
  );

endmodule

>>> sv/rpi_checker.sv
module rpi_checker #(
  parameter int LAT = 19
) (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        cfg_ready,
  input logic        done,
  input logic [59:0] new_orientation
);

  localparam int CW = $clog2(LAT + 1);

  logic [CW-1:0] since_rst;
  logic          warm;

  always_ff @(posedge clk) begin
    if (rst) begin
      since_rst <= '0;
    end else if (since_rst != CW'(LAT)) begin
      since_rst <= since_rst + 1'b1;
    end
  end

  assign warm = (since_rst == CW'(LAT));

  a_latency: assert property (@(posedge clk) disable iff (rst)
    warm |-> (done == $past(start && !busy, LAT)))
    else $error("result strobe does not match a transaction accepted earlier");

  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !busy && cfg_ready)
    else $error("input or configuration held off");

  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    done |-> (new_orientation != 60'd0))
    else $error("normalised quaternion is zero");

endmodule

bind rigid_pose_integrate_core rpi_checker #(.LAT(10 + 3 * NORM_ITERATIONS)) u_rpi_checker (
  .clk             (clk),
  .rst             (rst),
  .start           (start),
  .busy            (busy),
  .cfg_ready       (cfg_ready),
  .done            (done),
  .new_orientation (new_orientation)
);
